// ===== src/mec_pkg.sv =====
`default_nettype none

package mec_pkg;

	// Coordinate width inside the engine, 4 integer bits and the rest fraction
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = COORD_WIDTH - 4;
	localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
	localparam int IN_WIDTH    = 32;
	localparam int NARROW_SHIFT = (COORD_WIDTH < IN_WIDTH) ? IN_WIDTH - COORD_WIDTH : 0;

	localparam int ITER_WIDTH  = 16;
	localparam int COUNT_WIDTH = 32;

	localparam logic [ITER_WIDTH-1:0]  RESET_MAX_ITER = ITER_WIDTH'(1000);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX      = '1;

	// |z|^2 bound: 4.0 with 2*FRAC_BITS fraction bits
	localparam logic [PROD_WIDTH-1:0] MAG_BOUND =
		PROD_WIDTH'(1) << (2 * FRAC_BITS + 2);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic signed [IN_WIDTH-1:0] c_real;
		logic signed [IN_WIDTH-1:0] c_imag;
		logic                       clear_count;
	} in_t;

	typedef struct packed {
		logic                   escaped;
		logic [ITER_WIDTH-1:0]  iterations_done;
		logic [COUNT_WIDTH-1:0] outside_total;
	} out_t;

	// One classified request as it waits for the engine
	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] cr;
		logic signed [COORD_WIDTH-1:0] ci;
		logic                          clr;
		logic [ITER_WIDTH-1:0]         limit;
	} task_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_MUL,
		B_UPD,
		B_DONE
	} back_state_t;

	// Arithmetic shift right to the engine width, rounding toward minus infinity
	function automatic logic signed [COORD_WIDTH-1:0] narrow_coord(
		input logic signed [IN_WIDTH-1:0] v
	);
		logic signed [PROD_WIDTH-1:0] w;
		w = PROD_WIDTH'(v);
		return COORD_WIDTH'(w >>> NARROW_SHIFT);
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(
		input logic signed [PROD_WIDTH-1:0] v
	);
		logic signed [PROD_WIDTH-1:0] hi;
		logic signed [PROD_WIDTH-1:0] lo;
		hi = {{(PROD_WIDTH-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			return COORD_WIDTH'(hi);
		end else if (v < lo) begin
			return COORD_WIDTH'(lo);
		end
		return COORD_WIDTH'(v);
	endfunction

endpackage

`default_nettype wire

// ===== src/mandelbrot_escape_counter.sv =====
`default_nettype none

// Mandelbrot escape-time tester. Each request carries a point c (signed Q4.28) and
// returns one result: whether |z|^2 exceeded 4 within max_iterations updates of
// z = z*z + c (z starting at c), the update on which it escaped or the limit, and a
// saturating count of escaped points (clear_count zeroes it before the point is
// counted). In the engine each update is a multiply state through the shared set
// of three multipliers, then an update state for the add, clamp and escape test.
// A two-entry queue holds waiting requests so that input
// keeps flowing while the engine works and while a result waits at the output.
// Write max_iterations (reset 1000, zero acts as one) only while the block is idle.
module mandelbrot_escape_counter import mec_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [ITER_WIDTH-1:0] cfg_wr_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_t                   in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_t                       out_data
);

	logic  push_valid;
	logic  push_ready;
	task_t push_data;
	logic  pop_valid;
	logic  pop;
	task_t pop_data;

	mec_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	mec_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data)
	);

	mec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== src/mec_front.sv =====
`default_nettype none

module mec_front import mec_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [ITER_WIDTH-1:0] cfg_wr_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_t                   in_data,
	output logic                       push_valid,
	input  wire logic                  push_ready,
	output task_t                      push_data
);

	logic [ITER_WIDTH-1:0] max_iter_q;
	logic                  valid_s1;
	task_t                 task_s1;
	task_t                 task_new;

	always_comb begin
		task_new.cr    = narrow_coord(in_data.c_real);
		task_new.ci    = narrow_coord(in_data.c_imag);
		task_new.clr   = in_data.clear_count;
		// a zero limit still runs one update
		task_new.limit = (max_iter_q == '0) ? ITER_WIDTH'(1) : max_iter_q;
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = task_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= RESET_MAX_ITER;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_iter_q <= cfg_wr_data;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			task_s1 <= task_new;
		end
	end

endmodule

`default_nettype wire

// ===== src/mec_queue.sv =====
`default_nettype none

module mec_queue import mec_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire task_t push_data,
	output logic       pop_valid,
	input  wire logic  pop,
	output task_t      pop_data
);

	task_t                 mem [QUEUE_DEPTH];
	logic [QPTR_WIDTH-1:0] wr_ptr_q;
	logic [QPTR_WIDTH-1:0] rd_ptr_q;
	logic [QCNT_WIDTH-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (count_q != QCNT_WIDTH'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
				                                                       : wr_ptr_q + QPTR_WIDTH'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
				                                                       : rd_ptr_q + QPTR_WIDTH'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_WIDTH'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== src/mec_back.sv =====
`default_nettype none

module mec_back import mec_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  pop_valid,
	output logic       pop,
	input  wire task_t pop_data,
	output logic       out_valid,
	input  wire logic  out_ready,
	output out_t       out_data
);

	back_state_t state_q;
	back_state_t state_next;

	task_t                         task_q;
	logic signed [COORD_WIDTH-1:0] zr_q;
	logic signed [COORD_WIDTH-1:0] zi_q;
	logic [ITER_WIDTH-1:0]         n_q;
	logic signed [PROD_WIDTH-1:0]  rr_q;
	logic signed [PROD_WIDTH-1:0]  ii_q;
	logic signed [PROD_WIDTH-1:0]  ri_q;
	logic                          res_esc_q;
	logic [COUNT_WIDTH-1:0]        count_q;
	logic                          out_valid_q;
	out_t                          out_q;

	logic [PROD_WIDTH-1:0]         mag;
	logic signed [PROD_WIDTH-1:0]  re_sum;
	logic signed [PROD_WIDTH-1:0]  im_sum;
	logic                          esc_hit;
	logic                          at_limit;
	logic                          finish;
	logic                          out_load;
	logic [COUNT_WIDTH-1:0]        count_base;
	logic [COUNT_WIDTH-1:0]        count_new;

	// Datapath on the registered products of the current z
	assign mag      = $unsigned(rr_q) + $unsigned(ii_q);
	assign re_sum   = ((rr_q - ii_q) >>> FRAC_BITS) + PROD_WIDTH'(task_q.cr);
	assign im_sum   = (ri_q >>> (FRAC_BITS - 1)) + PROD_WIDTH'(task_q.ci);
	assign esc_hit  = (n_q != '0) && (mag > MAG_BOUND);
	assign at_limit = (n_q == task_q.limit);

	assign count_base = task_q.clr ? '0 : count_q;
	assign count_new  = (res_esc_q && count_base != COUNT_MAX) ? count_base + COUNT_WIDTH'(1)
	                                                            : count_base;

	always_comb begin
		state_next = state_q;
		case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					state_next = B_MUL;
				end
			end
			B_MUL: state_next = B_UPD;
			B_UPD: begin
				state_next = (esc_hit || at_limit) ? B_DONE : B_MUL;
			end
			B_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_next = B_IDLE;
				end
			end
			default: state_next = B_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		finish   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			B_IDLE: pop = pop_valid;
			B_UPD:  finish = esc_hit || at_limit;
			B_DONE: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (out_load) begin
				count_q     <= count_new;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			task_q <= pop_data;
			zr_q   <= pop_data.cr;
			zi_q   <= pop_data.ci;
			n_q    <= '0;
		end
		if (state_q == B_MUL) begin
			rr_q <= PROD_WIDTH'(zr_q) * PROD_WIDTH'(zr_q);
			ii_q <= PROD_WIDTH'(zi_q) * PROD_WIDTH'(zi_q);
			ri_q <= PROD_WIDTH'(zr_q) * PROD_WIDTH'(zi_q);
		end
		if (state_q == B_UPD) begin
			if (finish) begin
				res_esc_q <= esc_hit;
			end else begin
				zr_q <= clamp_coord(re_sum);
				zi_q <= clamp_coord(im_sum);
				n_q  <= n_q + ITER_WIDTH'(1);
			end
		end
		if (out_load) begin
			out_q.escaped         <= res_esc_q;
			out_q.iterations_done <= n_q;
			out_q.outside_total   <= count_new;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_iter_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_UPD) |-> (n_q <= task_q.limit))
		else $error("update count ran past the limit");

	a_count_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> $past(out_load))
		else $error("escape count changed without a result");

	a_iter_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (n_q != '0))
		else $error("result with zero updates");

endmodule

`default_nettype wire

// ===== test/escape_checker.sv =====
module escape_checker
	import mec_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [ITER_WIDTH-1:0] cfg_wr_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_t                   in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_t                  out_data,
	output int unsigned           fault_count,
	output int unsigned           results_owed
);

	// |z|^2 limit of 4.0 with 2*FRAC_BITS fraction bits
	localparam logic [63:0] ESCAPE_BOUND = 64'd4 << (2 * FRAC_BITS);

	logic [ITER_WIDTH-1:0]  iter_limit;
	logic [COUNT_WIDTH-1:0] escape_tally;
	out_t                   owed_q[$];
	out_t                   fresh;
	out_t                   oldest;
	int unsigned            faults;
	int unsigned            result_idx;

	function automatic longint pin_coord(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	// Iterate z = z*z + c from z = c; fills escaped and iterations_done
	function automatic out_t trace_orbit(input in_t pt, input logic [ITER_WIDTH-1:0] lim);
		longint      cr;
		longint      ci;
		longint      zr;
		longint      zi;
		longint      re_next;
		longint      im_next;
		logic [63:0] sq_re;
		logic [63:0] sq_im;
		int unsigned top;
		out_t        res;
		cr = longint'($signed(pt.c_real)) >>> NARROW_SHIFT;
		ci = longint'($signed(pt.c_imag)) >>> NARROW_SHIFT;
		zr = cr;
		zi = ci;
		top = (lim == 0) ? 1 : int'(lim);
		res = '0;
		res.iterations_done = ITER_WIDTH'(top);
		for (int unsigned n = 1; n <= top && !res.escaped; n++) begin
			re_next = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
			im_next = ((zr * zi) >>> (FRAC_BITS - 1)) + ci;
			zr = pin_coord(re_next);
			zi = pin_coord(im_next);
			sq_re = zr * zr;
			sq_im = zi * zi;
			if (sq_re + sq_im > ESCAPE_BOUND) begin
				res.escaped = 1'b1;
				res.iterations_done = ITER_WIDTH'(n);
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_limit = RESET_MAX_ITER;
			escape_tally = '0;
			owed_q.delete();
			faults = 0;
			result_idx = 0;
		end else begin
			if (cfg_wr_en) begin
				iter_limit = cfg_wr_data;
			end
			// check before predicting: a result cannot belong to a request taken this edge
			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					faults++;
					if (faults <= 10) begin
						$display("result %0d unexpected: esc=%0b iter=%0d total=%0d",
							result_idx, out_data.escaped, out_data.iterations_done,
							out_data.outside_total);
					end
				end else begin
					oldest = owed_q.pop_front();
					if (out_data.escaped !== oldest.escaped ||
							out_data.iterations_done !== oldest.iterations_done ||
							out_data.outside_total !== oldest.outside_total) begin
						faults++;
						if (faults <= 10) begin
							$display({"result %0d: expected esc=%0b iter=%0d total=%0d,",
								" got esc=%0b iter=%0d total=%0d"}, result_idx,
								oldest.escaped, oldest.iterations_done, oldest.outside_total,
								out_data.escaped, out_data.iterations_done,
								out_data.outside_total);
						end
					end
				end
				result_idx++;
			end
			if (in_valid && in_ready) begin
				if (in_data.clear_count) begin
					escape_tally = '0;
				end
				fresh = trace_orbit(in_data, iter_limit);
				if (fresh.escaped && escape_tally != COUNT_MAX) begin
					escape_tally++;
				end
				fresh.outside_total = escape_tally;
				owed_q.push_back(fresh);
			end
		end
		fault_count <= faults;
		results_owed <= owed_q.size();
	end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
	import mec_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000000;
	localparam int HOLD_CYCLES    = 300;
	localparam int UNIT           = 1 << 28;	// 1.0 in Q4.28
	localparam int C_MAX          = 32'h7FFFFFFF;
	localparam int C_MIN          = 32'h80000000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [ITER_WIDTH-1:0] cfg_wr_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_t                   in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_t                  out_data;
	int unsigned           fault_count;
	int unsigned           results_owed;

	bit                    send_gaps = 1'b1;
	bit                    rcv_gaps = 1'b1;
	bit                    hold_rcv = 1'b0;
	int unsigned           quiet_cycles = 0;
	logic [ITER_WIDTH-1:0] phase_limit;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	mandelbrot_escape_counter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

	escape_checker watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.fault_count  (fault_count),
		.results_owed (results_owed)
	);

	function automatic in_t make_point(input int re, input int im, input bit clr);
		in_t pt;
		pt.c_real = re;
		pt.c_imag = im;
		pt.clear_count = clr;
		return pt;
	endfunction

	// Mostly points around the set, some raw noise, some near the origin
	function automatic in_t pick_point();
		in_t         pt;
		int unsigned kind;
		kind = $urandom_range(99);
		pt.clear_count = ($urandom_range(9) == 0);
		if (kind < 20) begin
			pt.c_real = $urandom;
			pt.c_imag = $urandom;
		end else if (kind < 88) begin
			pt.c_real = int'($urandom_range(0, 3 * UNIT)) - (2 * UNIT + UNIT / 4);
			pt.c_imag = int'($urandom_range(0, 3 * UNIT)) - (UNIT + UNIT / 2);
		end else begin
			pt.c_real = int'($urandom) >>> 5;
			pt.c_imag = int'($urandom) >>> 5;
		end
		return pt;
	endfunction

	task automatic offer(input in_t pt);
		while (send_gaps && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= pt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Hold input until every outstanding request has its result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
	endtask

	task automatic set_limit(input logic [ITER_WIDTH-1:0] v);
		drain();
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_rcv) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rcv = 1'b0;
			end else begin
				out_ready <= !(rcv_gaps && $urandom_range(99) < 36);
			end
		end
	end

	initial begin : watchdog
		do begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end while (quiet_cycles < WATCHDOG_LIMIT);
		$display("mandelbrot_escape_counter: mismatch");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default limit after reset
		offer(make_point(0, 0, 1'b0));
		offer(make_point(C_MAX, C_MAX, 1'b0));
		offer(make_point(C_MIN, C_MIN, 1'b0));
		offer(make_point(C_MAX, C_MIN, 1'b0));
		offer(make_point(C_MIN, C_MAX, 1'b0));
		offer(make_point(-2 * UNIT, 0, 1'b0));
		offer(make_point(UNIT / 4, 0, 1'b0));
		offer(make_point(0, UNIT, 1'b0));
		offer(make_point(2 * UNIT, 2 * UNIT, 1'b1));
		offer(make_point(0, 0, 1'b1));
		offer(make_point(-1, -1, 1'b0));
		offer(make_point(1, 0, 1'b0));
		offer(make_point(4 * UNIT, 0, 1'b0));
		offer(make_point(-(3 * UNIT / 4), UNIT / 10, 1'b0));
		offer(make_point(UNIT / 4 + UNIT / 64, 0, 1'b0));

		// zero limit acts as one
		set_limit(16'd0);
		offer(make_point(0, 0, 1'b0));
		offer(make_point(2 * UNIT, 0, 1'b0));
		offer(make_point(UNIT, 0, 1'b0));
		offer(make_point(C_MIN, 0, 1'b1));

		// largest limit; the slow non-escaping point goes last and alone
		set_limit(16'hFFFF);
		offer(make_point(UNIT / 4 + UNIT / 1024, 0, 1'b0));
		offer(make_point(C_MAX, 0, 1'b0));
		offer(make_point(-2 * UNIT - 1, 0, 1'b0));
		drain();
		offer(make_point(0, 0, 1'b0));

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: phase_limit = ITER_WIDTH'(1);
				5: phase_limit = '0;
				7: phase_limit = RESET_MAX_ITER;
				3, 4: phase_limit = ITER_WIDTH'($urandom_range(33, 100));
				6: phase_limit = ITER_WIDTH'($urandom_range(101, 300));
				default: phase_limit = ITER_WIDTH'($urandom_range(2, 32));
			endcase
			set_limit(phase_limit);
			send_gaps = !(ph == 3 || ph == 4);
			rcv_gaps = send_gaps;
			if (ph == 2) begin
				hold_rcv = 1'b1;
			end
			for (int k = 0; k < 50; k++) begin
				if (ph == 6 && k == 25) begin
					drain();
				end
				offer(pick_point());
			end
		end

		drain();
		repeat (200) @(posedge clk);
		if (fault_count == 0 && results_owed == 0) begin
			$display("mandelbrot_escape_counter: match");
		end else begin
			$display("mandelbrot_escape_counter: mismatch");
		end
		$finish;
	end

endmodule
